[rtl/yuyv2rgb_pkg.sv]
// shared constants and types for the yuyv to rgb converter
`default_nettype none
package yuyv2rgb_pkg;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned CHR_W   = PIX_W + 1;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned COEF_W  = 18;
    localparam int unsigned SUM_W   = 27;
    localparam int unsigned WHOLE_W = SUM_W - FRAC_W - 1;
    localparam int unsigned PROD_W  = 2 * PIX_W;

    localparam logic [PIX_W-1:0]         CHROMA_MID = 8'd128;
    localparam logic [PIX_W-1:0]         CH_MAX     = 8'd255;
    localparam logic [PIX_W-1:0]         SCALE_MUL  = 8'd220;

    localparam logic signed [COEF_W-1:0] COEF_RV = 18'sd89831;
    localparam logic signed [COEF_W-1:0] COEF_GV = 18'sd45744;
    localparam logic signed [COEF_W-1:0] COEF_GU = 18'sd22127;
    localparam logic signed [COEF_W-1:0] COEF_BU = 18'sd113538;

    typedef struct packed {
        logic signed [SUM_W-1:0] rv;
        logic signed [SUM_W-1:0] gv;
        logic signed [SUM_W-1:0] gu;
        logic signed [SUM_W-1:0] bu;
    } t_chroma;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_rgb;

endpackage
`default_nettype wire

[rtl/yuyv2rgb_chroma.sv]
// shared chroma product stage feeding both pixel lanes
`default_nettype none
module yuyv2rgb_chroma
    import yuyv2rgb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [PIX_W-1:0] i_chroma_blue,
    input  wire logic [PIX_W-1:0] i_chroma_red,
    output t_chroma               o_chroma
);

    logic signed [CHR_W-1:0] cb;
    logic signed [CHR_W-1:0] cr;
    t_chroma                 n_chroma;
    t_chroma                 r_chroma;

    always_comb begin
        cb = $signed({1'b0, i_chroma_blue}) - $signed({1'b0, CHROMA_MID});
        cr = $signed({1'b0, i_chroma_red})  - $signed({1'b0, CHROMA_MID});
        n_chroma.rv = SUM_W'(cr) * SUM_W'(COEF_RV);
        n_chroma.gv = SUM_W'(cr) * SUM_W'(COEF_GV);
        n_chroma.gu = SUM_W'(cb) * SUM_W'(COEF_GU);
        n_chroma.bu = SUM_W'(cb) * SUM_W'(COEF_BU);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_chroma <= n_chroma;
        end
    end

    assign o_chroma = r_chroma;

endmodule
`default_nettype wire

[rtl/yuyv2rgb_lane.sv]
// one pixel lane: channel sums, floor, clamp and 220/256 scaling
`default_nettype none
module yuyv2rgb_lane
    import yuyv2rgb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [PIX_W-1:0] i_luma,
    input  wire t_chroma          i_chroma,
    output t_rgb                  o_rgb
);

    function automatic logic [PIX_W-1:0] finish_channel(input logic signed [SUM_W-1:0] sum);
        logic [WHOLE_W-1:0] whole;
        logic [PIX_W-1:0]   clamped;
        logic [PROD_W-1:0]  prod;
        whole = sum[SUM_W-2:FRAC_W];
        if (whole > WHOLE_W'(CH_MAX)) begin
            clamped = CH_MAX;
        end else begin
            clamped = whole[PIX_W-1:0];
        end
        prod = PROD_W'(clamped) * PROD_W'(SCALE_MUL);
        if (sum[SUM_W-1]) begin
            return '0;
        end
        return prod[PROD_W-1:PIX_W];
    endfunction

    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W-1:0] sum_r;
    logic signed [SUM_W-1:0] sum_g;
    logic signed [SUM_W-1:0] sum_b;
    t_rgb                    n_rgb;
    t_rgb                    r_rgb;

    always_comb begin
        base  = $signed({{(SUM_W-PIX_W-FRAC_W){1'b0}}, i_luma, {FRAC_W{1'b0}}});
        sum_r = base + i_chroma.rv;
        sum_g = base - i_chroma.gv - i_chroma.gu;
        sum_b = base + i_chroma.bu;
        n_rgb.red   = finish_channel(sum_r);
        n_rgb.green = finish_channel(sum_g);
        n_rgb.blue  = finish_channel(sum_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_rgb = r_rgb;

endmodule
`default_nettype wire

[rtl/yuyv_to_rgb_converter.sv]
// top level: yuyv group in, two rgb pixels out
// Each accepted YUYV word (two luma samples sharing one U and one V sample) gives
// one output word of two RGB pixels, every channel in 0..219. The block takes a new
// word every cycle while the output is not stalled. A word passes the shared chroma
// multiplier stage and then the per-pixel lane stage, the output register, to o_valid.
// While the output is stalled the chroma stage still takes one more word, and ready
// stays high whenever the output register is empty.
`default_nettype none
module yuyv_to_rgb_converter
    import yuyv2rgb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [PIX_W-1:0] i_luma_first,
    input  wire logic [PIX_W-1:0] i_chroma_blue,
    input  wire logic [PIX_W-1:0] i_luma_second,
    input  wire logic [PIX_W-1:0] i_chroma_red,
    input  wire logic             i_frame_last_in,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [PIX_W-1:0]      o_red_first,
    output logic [PIX_W-1:0]      o_green_first,
    output logic [PIX_W-1:0]      o_blue_first,
    output logic [PIX_W-1:0]      o_red_second,
    output logic [PIX_W-1:0]      o_green_second,
    output logic [PIX_W-1:0]      o_blue_second,
    output logic                  o_frame_last_out
);

    logic             r_v1;
    logic             r_v2;
    logic             n_v1;
    logic             n_v2;
    logic             en1;
    logic             en2;
    logic [PIX_W-1:0] r_luma_first;
    logic [PIX_W-1:0] r_luma_second;
    logic             r_last1;
    logic             r_last2;
    t_chroma          chroma;
    t_rgb             rgb_first;
    t_rgb             rgb_second;

    always_comb begin
        en2  = !r_v2 || i_ready;
        en1  = !r_v1 || en2;
        n_v1 = en1 ? i_valid : r_v1;
        n_v2 = en2 ? r_v1 : r_v2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_luma_first  <= i_luma_first;
            r_luma_second <= i_luma_second;
            r_last1       <= i_frame_last_in;
        end
        if (en2) begin
            r_last2 <= r_last1;
        end
    end

    yuyv2rgb_chroma u_chroma (
        .i_clk         (i_clk),
        .i_en          (en1),
        .i_chroma_blue (i_chroma_blue),
        .i_chroma_red  (i_chroma_red),
        .o_chroma      (chroma)
    );

    yuyv2rgb_lane u_lane_first (
        .i_clk    (i_clk),
        .i_en     (en2),
        .i_luma   (r_luma_first),
        .i_chroma (chroma),
        .o_rgb    (rgb_first)
    );

    yuyv2rgb_lane u_lane_second (
        .i_clk    (i_clk),
        .i_en     (en2),
        .i_luma   (r_luma_second),
        .i_chroma (chroma),
        .o_rgb    (rgb_second)
    );

    // merge both lanes into the output word
    assign o_ready          = en1;
    assign o_valid          = r_v2;
    assign o_red_first      = rgb_first.red;
    assign o_green_first    = rgb_first.green;
    assign o_blue_first     = rgb_first.blue;
    assign o_red_second     = rgb_second.red;
    assign o_green_second   = rgb_second.green;
    assign o_blue_second    = rgb_second.blue;
    assign o_frame_last_out = r_last2;

endmodule
`default_nettype wire

[rtl/yuyv2rgb_checker.sv]
// port-level checks for the yuyv to rgb converter
`default_nettype none
module yuyv2rgb_checker
    import yuyv2rgb_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_valid,
    input wire logic             o_ready,
    input wire logic             o_valid,
    input wire logic             i_ready,
    input wire logic [PIX_W-1:0] o_red_first,
    input wire logic [PIX_W-1:0] o_green_first,
    input wire logic [PIX_W-1:0] o_blue_first,
    input wire logic [PIX_W-1:0] o_red_second,
    input wire logic [PIX_W-1:0] o_green_second,
    input wire logic [PIX_W-1:0] o_blue_second
);

    localparam logic [PIX_W-1:0] OUT_MAX = 8'd219;

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_red_first <= OUT_MAX && o_green_first <= OUT_MAX &&
                     o_blue_first <= OUT_MAX && o_red_second <= OUT_MAX &&
                     o_green_second <= OUT_MAX && o_blue_second <= OUT_MAX))
        else $error("output channel above 219");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !o_valid) |=> ##1 o_valid)
        else $error("accepted word did not reach output in two cycles");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_red_first) &&
                                   $stable(o_blue_second)))
        else $error("stalled output word changed");

endmodule

bind yuyv_to_rgb_converter yuyv2rgb_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_red_first    (o_red_first),
    .o_green_first  (o_green_first),
    .o_blue_first   (o_blue_first),
    .o_red_second   (o_red_second),
    .o_green_second (o_green_second),
    .o_blue_second  (o_blue_second)
);
`default_nettype wire
